/* src/compression_unit_segmenter_unit_defines.svh */
// Assertion helpers used by the segmenter controller.
`ifndef COMPRESSION_UNIT_SEGMENTER_UNIT_DEFINES_SVH
`define COMPRESSION_UNIT_SEGMENTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CSU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/csu_pkg.sv */
`default_nettype none

package csu_pkg;

    localparam int OFFSET_BITS = 48;
    localparam int FLAG_BITS   = 8;
    localparam int LOG2_BITS   = 5;
    localparam int STATUS_BITS = 2;
    localparam int SEG_SLOTS   = 3;
    localparam int SLOT_BITS   = 2;

    // Unit size clamp
    localparam logic [LOG2_BITS-1:0] LOG2_MIN   = 5'd9;
    localparam logic [LOG2_BITS-1:0] LOG2_MAX   = 5'd24;
    localparam logic [LOG2_BITS-1:0] LOG2_RESET = 5'd16;

    // Register indexes
    localparam logic [0:0] REG_UNIT_SIZE_LOG2 = 1'b0;
    localparam logic [0:0] REG_ALLOCATED_SIZE = 1'b1;

    // Stream status codes
    localparam logic [STATUS_BITS-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_MISMATCH   = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_UNFINISHED = 2'd2;

    typedef logic [OFFSET_BITS-1:0] offs_t;
    typedef logic [FLAG_BITS-1:0]   flags_t;

    // Controller to datapath commands
    typedef struct packed {
        logic                 load;
        logic                 prep;
        logic                 seg;
        logic                 stat;
        logic                 zero_fill;
        logic [SLOT_BITS-1:0] wr_slot;
        logic [SLOT_BITS-1:0] rd_slot;
        logic                 rd_last;
    } csu_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic size_zero;
        logic last;
    } csu_stat_t;

    // One buffered segment result
    typedef struct packed {
        offs_t  seg_offset;
        offs_t  seg_size;
        flags_t seg_flags;
        offs_t  unit_logical_offset;
        offs_t  unit_phys_start;
        offs_t  unit_length;
        flags_t unit_flags;
        logic   unit_compressed;
        logic   unit_done;
    } seg_entry_t;

endpackage

`default_nettype wire

/* src/csu_datapath.sv */
`default_nettype none

module csu_datapath
    import csu_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [0:0]              cfg_index,
    input  wire logic [OFFSET_BITS-1:0]  cfg_data,
    input  wire logic [OFFSET_BITS-1:0]  run_offset,
    input  wire logic [OFFSET_BITS-1:0]  run_size,
    input  wire logic [FLAG_BITS-1:0]    run_flags,
    input  wire logic                    is_sparse,
    input  wire logic                    last_run,
    input  wire csu_cmd_t                cmd,
    output csu_stat_t                    stat,
    output logic [OFFSET_BITS-1:0]       seg_offset,
    output logic [OFFSET_BITS-1:0]       seg_size,
    output logic [FLAG_BITS-1:0]         seg_flags,
    output logic [OFFSET_BITS-1:0]       unit_logical_offset,
    output logic [OFFSET_BITS-1:0]       unit_phys_start,
    output logic [OFFSET_BITS-1:0]       unit_length,
    output logic [FLAG_BITS-1:0]         unit_flags,
    output logic                         unit_compressed,
    output logic                         unit_done,
    output logic                         last_of_run,
    output logic [STATUS_BITS-1:0]       status
);

    // Configuration registers
    logic [LOG2_BITS-1:0] unit_size_log2_reg;
    offs_t                allocated_size_reg;

    // Stream state
    logic   unit_open_reg, unit_open_next;
    offs_t  remaining_reg, remaining_next;
    offs_t  usize_reg, usize_next;
    flags_t uflags_reg, uflags_next;
    logic   ucomp_reg, ucomp_next;
    offs_t  ulogical_reg, ulogical_next;
    offs_t  uphys_reg, uphys_next;
    offs_t  next_logical_reg, next_logical_next;
    offs_t  size_sum_reg, size_sum_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;

    // Current run
    offs_t  run_off_reg, run_off_next;
    offs_t  run_size_reg, run_size_next;
    flags_t run_flags_reg;
    logic   run_sparse_reg;
    logic   run_last_reg;

    // Segment buffer
    seg_entry_t seg_buf [SEG_SLOTS];
    seg_entry_t rd_entry;
    seg_entry_t wr_entry;

    logic [LOG2_BITS-1:0] lg;
    offs_t cu;
    offs_t fresh_size;
    offs_t seg_len;
    logic  seg_closes;
    logic  fresh;

    // Clamped unit size and fresh unit length
    always_comb
    begin
        if (unit_size_log2_reg < LOG2_MIN)
            lg = LOG2_MIN;
        else if (unit_size_log2_reg > LOG2_MAX)
            lg = LOG2_MAX;
        else
            lg = unit_size_log2_reg;
        cu         = offs_t'(1) << lg;
        fresh      = !unit_open_reg;
        fresh_size = (run_size_reg <= cu) ? cu : (run_size_reg & ~(cu - offs_t'(1)));
        // remaining is never zero while a unit is open
        seg_closes = !(run_size_reg < remaining_reg);
        seg_len    = seg_closes ? remaining_reg : run_size_reg;
    end

    // Next-state logic for the stream
    always_comb
    begin
        unit_open_next    = unit_open_reg;
        remaining_next    = remaining_reg;
        usize_next        = usize_reg;
        uflags_next       = uflags_reg;
        ucomp_next        = ucomp_reg;
        ulogical_next     = ulogical_reg;
        uphys_next        = uphys_reg;
        next_logical_next = next_logical_reg;
        size_sum_next     = size_sum_reg;
        status_next       = status_reg;
        run_off_next      = run_off_reg;
        run_size_next     = run_size_reg;

        if (cmd.load)
        begin
            run_off_next  = run_offset;
            run_size_next = run_size;
            size_sum_next = size_sum_reg + run_size;
        end

        // Open a unit if needed, then apply run flags and sparse rules
        if (cmd.prep)
        begin
            if (fresh)
            begin
                unit_open_next = 1'b1;
                uphys_next     = run_off_reg;
                ulogical_next  = next_logical_reg;
                usize_next     = fresh_size;
                remaining_next = fresh_size;
                uflags_next    = '0;
                ucomp_next     = 1'b0;
            end
            if (!run_sparse_reg)
                uflags_next = run_flags_reg;
            else if (!fresh && (remaining_reg < cu))
            begin
                ucomp_next = 1'b1;
                // short sparse last run closes the unit
                if (run_last_reg && (run_size_reg < remaining_reg))
                    remaining_next = run_size_reg;
            end
        end

        // Cut one segment
        if (cmd.seg)
        begin
            if (!run_sparse_reg)
                run_off_next = run_off_reg + seg_len;
            run_size_next  = run_size_reg - seg_len;
            remaining_next = remaining_reg - seg_len;
            if (seg_closes)
            begin
                next_logical_next = next_logical_reg + usize_reg;
                unit_open_next    = 1'b0;
            end
        end

        // End of run: status, and stream clear after the last run
        if (cmd.stat)
        begin
            if (!run_last_reg)
                status_next = STATUS_OK;
            else if (size_sum_reg != allocated_size_reg)
                status_next = STATUS_MISMATCH;
            else if (unit_open_reg)
                status_next = STATUS_UNFINISHED;
            else
                status_next = STATUS_OK;

            if (run_last_reg)
            begin
                unit_open_next    = 1'b0;
                remaining_next    = '0;
                usize_next        = '0;
                uflags_next       = '0;
                ucomp_next        = 1'b0;
                ulogical_next     = '0;
                uphys_next        = '0;
                next_logical_next = '0;
                size_sum_next     = '0;
            end
        end
    end

    // Configuration and stream state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_size_log2_reg <= LOG2_RESET;
            allocated_size_reg <= '0;
            unit_open_reg      <= 1'b0;
            remaining_reg      <= '0;
            usize_reg          <= '0;
            uflags_reg         <= '0;
            ucomp_reg          <= 1'b0;
            ulogical_reg       <= '0;
            uphys_reg          <= '0;
            next_logical_reg   <= '0;
            size_sum_reg       <= '0;
            status_reg         <= STATUS_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_UNIT_SIZE_LOG2)
                    unit_size_log2_reg <= cfg_data[LOG2_BITS-1:0];
                else
                    allocated_size_reg <= cfg_data;
            end
            unit_open_reg    <= unit_open_next;
            remaining_reg    <= remaining_next;
            usize_reg        <= usize_next;
            uflags_reg       <= uflags_next;
            ucomp_reg        <= ucomp_next;
            ulogical_reg     <= ulogical_next;
            uphys_reg        <= uphys_next;
            next_logical_reg <= next_logical_next;
            size_sum_reg     <= size_sum_next;
            status_reg       <= status_next;
        end
    end

    // Run payload registers
    always_ff @(posedge clk)
    begin
        run_off_reg  <= run_off_next;
        run_size_reg <= run_size_next;
        if (cmd.load)
        begin
            run_flags_reg  <= run_flags;
            run_sparse_reg <= is_sparse;
            run_last_reg   <= last_run;
        end
    end

    // Segment word built from the unit state after prep
    always_comb
    begin
        wr_entry.seg_offset          = run_off_reg;
        wr_entry.seg_size            = seg_len;
        wr_entry.seg_flags           = run_flags_reg;
        wr_entry.unit_logical_offset = ulogical_reg;
        wr_entry.unit_phys_start     = uphys_reg;
        wr_entry.unit_length         = usize_reg;
        wr_entry.unit_flags          = uflags_reg;
        wr_entry.unit_compressed     = ucomp_reg;
        wr_entry.unit_done           = seg_closes;
    end

    // Buffer writes
    always_ff @(posedge clk)
    begin
        if (cmd.seg)
            seg_buf[cmd.wr_slot] <= wr_entry;
        else if (cmd.zero_fill)
            seg_buf[0] <= '0;
    end

    assign rd_entry = seg_buf[cmd.rd_slot];

    assign stat.size_zero = (run_size_reg == '0);
    assign stat.last      = run_last_reg;

    assign seg_offset          = rd_entry.seg_offset;
    assign seg_size            = rd_entry.seg_size;
    assign seg_flags           = rd_entry.seg_flags;
    assign unit_logical_offset = rd_entry.unit_logical_offset;
    assign unit_phys_start     = rd_entry.unit_phys_start;
    assign unit_length         = rd_entry.unit_length;
    assign unit_flags          = rd_entry.unit_flags;
    assign unit_compressed     = rd_entry.unit_compressed;
    assign unit_done           = rd_entry.unit_done;
    assign last_of_run         = cmd.rd_last;
    assign status              = status_reg;

endmodule

`default_nettype wire

/* src/csu_controller.sv */
`default_nettype none
`include "compression_unit_segmenter_unit_defines.svh"

module csu_controller
    import csu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    input  wire csu_stat_t stat,
    output csu_cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_SEG  = 3'd2;
    localparam logic [2:0] ST_STAT = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam logic [SLOT_BITS-1:0] SLOT_FULL = SLOT_BITS'(SEG_SLOTS);

    logic [2:0]           state_reg, state_next;
    logic [SLOT_BITS-1:0] n_reg, n_next;
    logic [SLOT_BITS-1:0] k_reg, k_next;
    logic                 accept;
    logic                 k_last;

    assign accept = in_valid && !in_stall;
    assign k_last = (SLOT_BITS'(k_reg + 2'd1) == n_reg);

    // Sequencer: prep and cut up to three segments, then emit them
    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        cmd           = '0;
        cmd.wr_slot   = n_reg;
        cmd.rd_slot   = k_reg;
        cmd.rd_last   = k_last;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    n_next     = '0;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (stat.size_zero || (n_reg == SLOT_FULL))
                    state_next = ST_STAT;
                else
                begin
                    cmd.prep   = 1'b1;
                    state_next = ST_SEG;
                end
            end
            ST_SEG:
            begin
                cmd.seg    = 1'b1;
                n_next     = n_reg + 2'd1;
                state_next = ST_PREP;
            end
            ST_STAT:
            begin
                cmd.stat = 1'b1;
                k_next   = '0;
                if (n_reg != '0)
                    state_next = ST_EMIT;
                else if (stat.last)
                begin
                    // empty last run still reports its status
                    cmd.zero_fill = 1'b1;
                    n_next        = 2'd1;
                    state_next    = ST_EMIT;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    if (k_last)
                        state_next = ST_IDLE;
                    else
                        k_next = k_reg + 2'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);

    // Checks
    `CSU_ASSERT_IMP(a_emit_in_range, clk, rst_n, out_valid, (n_reg != '0) && (k_reg < n_reg), "emit index outside filled slots")
    `CSU_ASSERT_NXT(a_seg_counts, clk, rst_n, state_reg == ST_SEG, n_reg == SLOT_BITS'($past(n_reg) + 2'd1), "segment count did not advance")
    `CSU_ASSERT_NXT(a_accept_starts, clk, rst_n, accept, (state_reg == ST_PREP) && (n_reg == '0), "accepted run did not start cutting")
    `CSU_ASSERT_NXT(a_final_word_idle, clk, rst_n, out_valid && !out_stall && k_last, state_reg == ST_IDLE, "no return to idle after final word")

endmodule

`default_nettype wire

/* src/compression_unit_segmenter_unit.sv */
// Compression unit segmenter. Each accepted run (offset, size, flags, sparse and
// last marks) is cut into at most three segments that fill compression units, and
// one word per segment goes out, carrying the segment and the unit it belongs to.
// A run is worked by a sequencer that, per segment, preps the unit and then cuts
// the segment into a three-entry result buffer; then it writes the status and sends
// the words out. A zero-size run that is not last gives no word. The input stalls
// from acceptance until the last word of the run is taken. On the last run every
// word carries the stream status (size mismatch before unfinished unit) and the
// stream state clears; a zero-size last run gives a single status-only word. The
// user must write configuration through cfg_we/cfg_index/cfg_data only while the
// block is idle; the block itself does not enforce this.
`default_nettype none

module compression_unit_segmenter_unit
    import csu_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [0:0]              cfg_index,
    input  wire logic [OFFSET_BITS-1:0]  cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [OFFSET_BITS-1:0]  run_offset,
    input  wire logic [OFFSET_BITS-1:0]  run_size,
    input  wire logic [FLAG_BITS-1:0]    run_flags,
    input  wire logic                    is_sparse,
    input  wire logic                    last_run,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [OFFSET_BITS-1:0]       seg_offset,
    output logic [OFFSET_BITS-1:0]       seg_size,
    output logic [FLAG_BITS-1:0]         seg_flags,
    output logic [OFFSET_BITS-1:0]       unit_logical_offset,
    output logic [OFFSET_BITS-1:0]       unit_phys_start,
    output logic [OFFSET_BITS-1:0]       unit_length,
    output logic [FLAG_BITS-1:0]         unit_flags,
    output logic                         unit_compressed,
    output logic                         unit_done,
    output logic                         last_of_run,
    output logic [STATUS_BITS-1:0]       status
);

    csu_cmd_t  cmd;
    csu_stat_t stat;

    csu_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    csu_datapath u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .run_offset          (run_offset),
        .run_size            (run_size),
        .run_flags           (run_flags),
        .is_sparse           (is_sparse),
        .last_run            (last_run),
        .cmd                 (cmd),
        .stat                (stat),
        .seg_offset          (seg_offset),
        .seg_size            (seg_size),
        .seg_flags           (seg_flags),
        .unit_logical_offset (unit_logical_offset),
        .unit_phys_start     (unit_phys_start),
        .unit_length         (unit_length),
        .unit_flags          (unit_flags),
        .unit_compressed     (unit_compressed),
        .unit_done           (unit_done),
        .last_of_run         (last_of_run),
        .status              (status)
    );

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench
    import csu_pkg::*;
();

    // One expected output word
    typedef struct packed {
        offs_t                  seg_offset;
        offs_t                  seg_size;
        flags_t                 seg_flags;
        offs_t                  unit_logical;
        offs_t                  unit_phys;
        offs_t                  unit_len;
        flags_t                 unit_flags;
        logic                   compressed;
        logic                   done;
        logic                   last;
        logic [STATUS_BITS-1:0] status;
    } seg_word_t;

    // One input run, held while a stream is built
    typedef struct packed {
        offs_t  offset;
        offs_t  size;
        flags_t flags;
        logic   sparse;
        logic   last;
    } run_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [0:0]             cfg_index = REG_UNIT_SIZE_LOG2;
    offs_t                  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    offs_t                  run_offset = '0;
    offs_t                  run_size = '0;
    flags_t                 run_flags = '0;
    logic                   is_sparse = 1'b0;
    logic                   last_run = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    offs_t                  seg_offset;
    offs_t                  seg_size;
    flags_t                 seg_flags;
    offs_t                  unit_logical_offset;
    offs_t                  unit_phys_start;
    offs_t                  unit_length;
    flags_t                 unit_flags;
    logic                   unit_compressed;
    logic                   unit_done;
    logic                   last_of_run;
    logic [STATUS_BITS-1:0] status;

    compression_unit_segmenter_unit DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .run_offset          (run_offset),
        .run_size            (run_size),
        .run_flags           (run_flags),
        .is_sparse           (is_sparse),
        .last_run            (last_run),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .seg_offset          (seg_offset),
        .seg_size            (seg_size),
        .seg_flags           (seg_flags),
        .unit_logical_offset (unit_logical_offset),
        .unit_phys_start     (unit_phys_start),
        .unit_length         (unit_length),
        .unit_flags          (unit_flags),
        .unit_compressed     (unit_compressed),
        .unit_done           (unit_done),
        .last_of_run         (last_of_run),
        .status              (status)
    );

    always #5 clk = ~clk;

    // Register copies and stream state of the segment predictor
    logic [LOG2_BITS-1:0] unit_log2 = LOG2_RESET;
    offs_t                alloc_size = '0;
    logic                 u_open = 1'b0;
    offs_t                u_remaining = '0;
    offs_t                u_size = '0;
    flags_t               u_flags = '0;
    logic                 u_compressed = 1'b0;
    offs_t                u_logical = '0;
    offs_t                u_phys = '0;
    offs_t                next_logical = '0;
    offs_t                bytes_total = '0;

    seg_word_t expected_words[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int words_checked = 0;
    int runs_sent = 0;
    int streams_sent = 0;

    // Cut one accepted run into segments and queue the words it must produce
    task automatic predict_segments(input offs_t offset, input offs_t size,
                                    input flags_t flags, input logic sparse,
                                    input logic last);
        seg_word_t              words[3];
        logic [LOG2_BITS-1:0]   lg;
        offs_t                  cu;
        offs_t                  seg;
        logic [STATUS_BITS-1:0] stream_status;
        int                     n;
        lg = unit_log2;
        if (lg < LOG2_MIN)
            lg = LOG2_MIN;
        if (lg > LOG2_MAX)
            lg = LOG2_MAX;
        cu = offs_t'(1) << lg;
        bytes_total = bytes_total + size;
        n = 0;
        while (size != 0 && n < SEG_SLOTS)
        begin
            // fresh unit: one unit size, or the whole multiple for a long run
            if (!u_open)
            begin
                u_open = 1'b1;
                u_phys = offset;
                u_logical = next_logical;
                u_size = (size <= cu) ? cu : (size & ~(cu - 1));
                u_remaining = u_size;
                u_flags = '0;
                u_compressed = 1'b0;
            end
            if (!sparse)
                u_flags = flags;
            else if (u_remaining < cu)
            begin
                u_compressed = 1'b1;
                // short sparse last run closes the unit
                if (last && size < u_remaining)
                    u_remaining = size;
            end
            seg = (size < u_remaining) ? size : u_remaining;
            words[n] = '0;
            words[n].seg_offset = offset;
            words[n].seg_size = seg;
            words[n].seg_flags = flags;
            if (!sparse)
                offset = offset + seg;
            size = size - seg;
            u_remaining = u_remaining - seg;
            words[n].unit_logical = u_logical;
            words[n].unit_phys = u_phys;
            words[n].unit_len = u_size;
            words[n].unit_flags = u_flags;
            words[n].compressed = u_compressed;
            words[n].done = (u_remaining == 0);
            if (u_remaining == 0)
            begin
                next_logical = next_logical + u_size;
                u_open = 1'b0;
            end
            n++;
        end
        // last run: status on every word, then the stream starts over
        if (last)
        begin
            if (bytes_total != alloc_size)
                stream_status = STATUS_MISMATCH;
            else if (u_open)
                stream_status = STATUS_UNFINISHED;
            else
                stream_status = STATUS_OK;
            if (n == 0)
            begin
                words[0] = '0;
                n = 1;
            end
            for (int k = 0; k < n; k++)
                words[k].status = stream_status;
            u_open = 1'b0;
            u_remaining = '0;
            u_size = '0;
            u_flags = '0;
            u_compressed = 1'b0;
            u_logical = '0;
            u_phys = '0;
            next_logical = '0;
            bytes_total = '0;
        end
        if (n > 0)
            words[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            expected_words.push_back(words[k]);
    endtask

    function automatic void compare_field(input string name, input offs_t want,
                                          input offs_t got);
        if (got !== want)
        begin
            $error("%s: expected %h, actual %h", name, want, got);
            fail_count++;
        end
    endfunction

    // Output side: check each taken word, then pick the next stall
    always @(posedge clk)
    begin
        seg_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("output word with no expectation waiting");
                fail_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                compare_field("seg_offset", want.seg_offset, seg_offset);
                compare_field("seg_size", want.seg_size, seg_size);
                compare_field("seg_flags", offs_t'(want.seg_flags), offs_t'(seg_flags));
                compare_field("unit_logical_offset", want.unit_logical,
                              unit_logical_offset);
                compare_field("unit_phys_start", want.unit_phys, unit_phys_start);
                compare_field("unit_length", want.unit_len, unit_length);
                compare_field("unit_flags", offs_t'(want.unit_flags),
                              offs_t'(unit_flags));
                compare_field("unit_compressed", offs_t'(want.compressed),
                              offs_t'(unit_compressed));
                compare_field("unit_done", offs_t'(want.done), offs_t'(unit_done));
                compare_field("last_of_run", offs_t'(want.last), offs_t'(last_of_run));
                compare_field("status", offs_t'(want.status), offs_t'(status));
                words_checked++;
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Send one run; valid stays high afterwards so back-to-back runs need no gap
    task automatic send_run(input offs_t offset, input offs_t size, input flags_t flags,
                            input logic sparse, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        run_offset <= offset;
        run_size <= size;
        run_flags <= flags;
        is_sparse <= sparse;
        last_run <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_segments(offset, size, flags, sparse, last);
        runs_sent++;
        if (last)
            streams_sent++;
    endtask

    // Drop valid, wait for every expected word, then let the sequencer settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] index, input offs_t value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (index == REG_UNIT_SIZE_LOG2)
            unit_log2 = value[LOG2_BITS-1:0];
        else
            alloc_size = value;
    endtask

    // 512-byte units: tail, whole units and new unit in one run; sparse runs
    task automatic test_unit_cutting();
        wait_idle();
        write_reg(REG_UNIT_SIZE_LOG2, 48'd9);
        write_reg(REG_ALLOCATED_SIZE, 48'd2400);
        send_run(48'h1000, 48'd100, 8'hA5, 1'b0, 1'b0);
        send_run(48'h2000, 48'd200, 8'h00, 1'b1, 1'b0);   // sparse in partly filled unit
        send_run(48'h3000, 48'd2000, 8'h3C, 1'b0, 1'b0);  // three segments
        send_run(48'h4000, 48'd0, 8'h11, 1'b0, 1'b0);     // zero size, no word
        send_run(48'h5000, 48'd100, 8'h5A, 1'b1, 1'b1);   // short sparse last run
        // exactly one unit
        wait_idle();
        write_reg(REG_ALLOCATED_SIZE, 48'd512);
        send_run(48'h8000_0000_0000, 48'd512, 8'h96, 1'b0, 1'b1);
    endtask

    // Unit size below and above the clamp; mismatch wins over unfinished unit
    task automatic test_unit_size_clamp();
        wait_idle();
        write_reg(REG_UNIT_SIZE_LOG2, 48'd0);
        write_reg(REG_ALLOCATED_SIZE, 48'd0);
        send_run(48'hFFFF_FFFF_FFFF, 48'h300, 8'hFF, 1'b0, 1'b0);  // offset wraps
        send_run(48'h0, 48'h10, 8'h00, 1'b0, 1'b1);
        // sparse run on a fresh unit is not compressed; unit left open
        wait_idle();
        write_reg(REG_UNIT_SIZE_LOG2, 48'd31);
        write_reg(REG_ALLOCATED_SIZE, 48'd1024);
        send_run(48'h0, 48'd1000, 8'h81, 1'b1, 1'b0);
        send_run(48'h7777, 48'd24, 8'h42, 1'b0, 1'b1);
    endtask

    // Zero-size last runs and the largest run size
    task automatic test_zero_size_last();
        wait_idle();
        write_reg(REG_UNIT_SIZE_LOG2, 48'd24);
        write_reg(REG_ALLOCATED_SIZE, 48'hFFFF_FFFF_FFFF);
        send_run(48'h1234_5678_9ABC, 48'hFFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0);
        send_run(48'h0, 48'h0, 8'h00, 1'b0, 1'b1);
        send_run(48'hABC, 48'h0, 8'hFF, 1'b1, 1'b1);
        wait_idle();
        write_reg(REG_ALLOCATED_SIZE, 48'd0);
        send_run(48'h5555_AAAA_5555, 48'h0, 8'h33, 1'b0, 1'b1);
    endtask

    // Random streams: random content, mostly matching allocated size
    task automatic test_random_streams(input int run_budget);
        run_t                 runs[$];
        run_t                 r;
        offs_t                total;
        offs_t                cu;
        logic [LOG2_BITS-1:0] lg;
        int                   sent;
        int                   nruns;
        sent = 0;
        while (sent < run_budget)
        begin
            runs.delete();
            total = '0;
            case ($urandom_range(9))
                0: lg = LOG2_BITS'($urandom_range(31));
                1: lg = LOG2_MAX;
                default: lg = LOG2_BITS'($urandom_range(12, 9));
            endcase
            cu = offs_t'(1) << ((lg < LOG2_MIN) ? LOG2_MIN : (lg > LOG2_MAX) ? LOG2_MAX : lg);
            nruns = $urandom_range(8, 1);
            for (int i = 0; i < nruns; i++)
            begin
                r.offset = offs_t'({$urandom, $urandom});
                r.flags = FLAG_BITS'($urandom);
                r.sparse = ($urandom_range(3) == 0);
                r.last = (i == nruns - 1);
                case ($urandom_range(9))
                    0: r.size = '0;
                    1: r.size = offs_t'({$urandom, $urandom});
                    2: r.size = cu * offs_t'($urandom_range(4, 1));
                    3, 4: r.size = offs_t'($urandom_range(64, 1));
                    default: r.size = offs_t'($urandom_range(32'(3 * cu), 1));
                endcase
                total = total + r.size;
                runs.push_back(r);
            end
            wait_idle();
            write_reg(REG_UNIT_SIZE_LOG2, offs_t'(lg));
            if ($urandom_range(3) == 0)
                write_reg(REG_ALLOCATED_SIZE, offs_t'({$urandom, $urandom}));
            else
                write_reg(REG_ALLOCATED_SIZE, total);
            foreach (runs[i])
                send_run(runs[i].offset, runs[i].size, runs[i].flags,
                         runs[i].sparse, runs[i].last);
            sent += nruns;
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 17;
        recv_stall_pct = 76;
        test_unit_cutting();
        test_unit_size_clamp();
        test_zero_size_last();
        test_random_streams(45);
        send_idle_pct = 76;
        recv_stall_pct = 17;
        test_random_streams(45);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_streams(45);
        wait_idle();
        $display("Run summary: %0d runs in %0d streams, %0d segment words checked",
                 runs_sent, streams_sent, words_checked);
        $display("Unit sizes from 2^9 to 2^24 incl. clamped settings, under three idle mixes");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Hang guard
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* compression_unit_segmenter_unit.f */
+incdir+src
src/csu_pkg.sv
src/csu_datapath.sv
src/csu_controller.sv
src/compression_unit_segmenter_unit.sv
bench/testbench.sv
